// ===== sv/etsfd_pkg.sv =====
// Shared types and constants for the edge timing sensor frame decoder.
`default_nettype none

package etsfd_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LENGTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 3'd6;

  // Frame layout.
  localparam int unsigned    FRAME_W           = 40;
  localparam logic [5:0]     FRAME_BITS        = 6'd40;
  localparam int unsigned    LAST_CHECKED_EDGE = 82;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_START    = 3'd1,
    ST_TIMING   = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_POLARITY = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_END   = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        edge_rising;
    logic [15:0] capture_time;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } out_item_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        edge_rising;
    logic [15:0] capture_time;
  } op_t;

  typedef struct packed {
    logic [15:0] start_length;
    logic [15:0] bit_gap_length;
    logic [15:0] byte_gap_length;
    logic [15:0] zero_min;
    logic [15:0] zero_max;
    logic [15:0] one_length;
    logic [7:0]  tolerance;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== sv/etsfd_front.sv =====
// Front end: decodes input beats into operations and queues them for the back end.
`default_nettype none

module etsfd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire etsfd_pkg::in_item_t in_data,
  output logic                    op_valid,
  input  wire logic               op_ready,
  output etsfd_pkg::op_t          op_data
);
  import etsfd_pkg::*;

  op_t        q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  op_t        dec_op;
  logic       dec_keep;
  logic       push, pop;

  // Classify the command; the unused code is accepted and dropped here.
  always_comb begin
    dec_op.edge_rising  = in_data.edge_rising;
    dec_op.capture_time = in_data.capture_time;
    dec_keep            = 1'b1;
    case (in_data.command)
      CMD_START: dec_op.kind = OP_START;
      CMD_EDGE:  dec_op.kind = OP_EDGE;
      CMD_END:   dec_op.kind = OP_END;
      default: begin
        dec_op.kind = OP_EDGE;
        dec_keep    = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready && dec_keep;
  assign op_valid = (count_r != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op_data  = q_mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_op;
    end
  end

endmodule

`default_nettype wire

// ===== sv/etsfd_back.sv =====
// Back end: frame state, interval window checks, bit assembly and the result register.
`default_nettype none

module etsfd_back #(
  parameter int MAX_EDGES  = 84,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire etsfd_pkg::cfg_regs_t cfg,
  input  wire logic                 op_valid,
  output logic                      op_ready,
  input  wire etsfd_pkg::op_t       op_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output etsfd_pkg::out_item_t      out_data
);
  import etsfd_pkg::*;

  localparam int TW_IN = (TIME_WIDTH < 16) ? TIME_WIDTH : 16;
  localparam int CW    = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  logic [TW_IN-1:0]   prev_r, prev_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               ffall_r, ffall_nxt;
  status_t            err_r, err_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [5:0]         bits_r, bits_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [TW_IN-1:0]      t_in;
  logic [TIME_WIDTH-1:0] dt;
  logic [CW-1:0]         dt_c;
  logic [CNT_W-1:0]      j;
  logic                  ok_start, ok_bit_gap, ok_byte_gap, ok_zero, ok_one;
  logic [7:0]            sum;

  // True when v lies within nominal plus or minus tol, the low end clamped at zero.
  function automatic logic near_win(input logic [CW-1:0] v, input logic [15:0] nom,
                                    input logic [7:0] tol);
    logic [15:0] lo;
    logic [16:0] hi;
    lo = (nom > 16'(tol)) ? nom - 16'(tol) : 16'd0;
    hi = 17'(nom) + 17'(tol);
    return (v >= CW'(lo)) && (v <= CW'(hi));
  endfunction

  // Interval since the previous edge, modulo the timer width, and its window checks.
  always_comb begin
    t_in        = op_data.capture_time[TW_IN-1:0];
    dt          = TIME_WIDTH'(t_in) - TIME_WIDTH'(prev_r);
    dt_c        = CW'(dt);
    ok_start    = near_win(dt_c, cfg.start_length, cfg.tolerance);
    ok_bit_gap  = near_win(dt_c, cfg.bit_gap_length, cfg.tolerance);
    ok_byte_gap = near_win(dt_c, cfg.byte_gap_length, cfg.tolerance);
    ok_one      = near_win(dt_c, cfg.one_length, cfg.tolerance);
    ok_zero     = (dt_c >= CW'(cfg.zero_min)) && (dt_c <= CW'(cfg.zero_max));
    j           = cnt_r - CNT_W'(4);
    sum         = frame_r[39:32] + frame_r[31:24] + frame_r[23:16] + frame_r[15:8];
  end

  // An end beat waits only for room in the result register.
  assign op_ready = (op_data.kind != OP_END) || !out_valid_r || out_ready;

  // Step the frame state by one operation.
  always_comb begin
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    ffall_nxt     = ffall_r;
    err_nxt       = err_r;
    frame_nxt     = frame_r;
    bits_nxt      = bits_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (op_valid && op_ready) begin
      case (op_data.kind)
        OP_START: begin
          prev_nxt  = '0;
          cnt_nxt   = '0;
          last_nxt  = 1'b0;
          ffall_nxt = 1'b0;
          err_nxt   = ST_OK;
          frame_nxt = '0;
          bits_nxt  = '0;
        end
        OP_EDGE: begin
          if (err_r != ST_OK) begin
            // A latched error freezes the frame until the next start.
          end else if (cnt_r >= CNT_W'(MAX_EDGES)) begin
            err_nxt = ST_OVERFLOW;
          end else if (cnt_r == '0) begin
            last_nxt  = op_data.edge_rising;
            ffall_nxt = !op_data.edge_rising;
            if (op_data.edge_rising) begin
              err_nxt = ST_START;
            end
            prev_nxt = t_in;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end else if (op_data.edge_rising == last_r) begin
            err_nxt = ST_POLARITY;
          end else begin
            last_nxt = op_data.edge_rising;
            prev_nxt = t_in;
            cnt_nxt  = cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(1) || cnt_r == CNT_W'(2)) begin
              if (!ok_start) begin
                err_nxt = ST_START;
              end
            end else if (cnt_r == CNT_W'(3)) begin
              if (!ok_bit_gap) begin
                err_nxt = ST_TIMING;
              end
            end else if (cnt_r > CNT_W'(LAST_CHECKED_EDGE)) begin
              // Surplus edges are counted but not checked.
            end else if (!j[0]) begin
              // High pulse: one data bit.
              if (ok_zero || ok_one) begin
                frame_nxt = {frame_r[FRAME_W-2:0], !ok_zero};
                bits_nxt  = bits_r + 6'd1;
              end else begin
                err_nxt = ST_TIMING;
              end
            end else if (j[3:1] == 3'b111) begin
              if (!ok_byte_gap) begin
                err_nxt = ST_TIMING;
              end
            end else begin
              if (!ok_bit_gap) begin
                err_nxt = ST_TIMING;
              end
            end
          end
        end
        OP_END: begin
          out_valid_nxt       = 1'b1;
          out_nxt.humidity    = '0;
          out_nxt.temperature = '0;
          if (err_r != ST_OK) begin
            out_nxt.status = err_r;
          end else if (cnt_r == '0 || !ffall_r) begin
            out_nxt.status = ST_START;
          end else if (bits_r < FRAME_BITS) begin
            out_nxt.status = ST_TIMING;
          end else begin
            out_nxt.humidity    = frame_r[39:24];
            out_nxt.temperature = frame_r[23:8];
            out_nxt.status      = (sum == frame_r[7:0]) ? ST_OK : ST_CHECKSUM;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      ffall_r     <= 1'b0;
      err_r       <= ST_OK;
      frame_r     <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      ffall_r     <= ffall_nxt;
      err_r       <= err_nxt;
      frame_r     <= frame_nxt;
      bits_r      <= bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sv/edge_timing_sensor_frame_decoder_unit.sv =====
// Top level of the edge timing sensor frame decoder: configuration registers and the two halves.
`default_nettype none

// Decodes one single-wire sensor frame from timestamped edge beats. The block takes one input
// beat per clock cycle while its queue has room: the front end decodes each beat into a
// two-entry queue, and the back end applies one queued operation per cycle unless an end command
// waits for the result register, each edge passing through the back end's interval subtract and
// window compare. An end command produces one result beat in the cycle after the back end takes
// it; it waits there only while the output register holds a result that has not been taken, and
// the queue absorbs one further beat meanwhile. A start command clears the frame state.
// Configuration writes are meant for idle periods only, and writes to an index past the last
// register are ignored.
module edge_timing_sensor_frame_decoder_unit #(
  parameter int MAX_EDGES  = 84,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire etsfd_pkg::in_item_t                     in_data,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output etsfd_pkg::out_item_t                         out_data,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [etsfd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [15:0]                             cfg_data
);
  import etsfd_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      op_valid, op_ready;
  op_t       op_data;

  assign cfg_ready = 1'b1;

  // Configuration register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_START_LENGTH:    cfg_nxt.start_length    = cfg_data;
        CFG_BIT_GAP_LENGTH:  cfg_nxt.bit_gap_length  = cfg_data;
        CFG_BYTE_GAP_LENGTH: cfg_nxt.byte_gap_length = cfg_data;
        CFG_ZERO_MIN:        cfg_nxt.zero_min        = cfg_data;
        CFG_ZERO_MAX:        cfg_nxt.zero_max        = cfg_data;
        CFG_ONE_LENGTH:      cfg_nxt.one_length      = cfg_data;
        CFG_TOLERANCE:       cfg_nxt.tolerance       = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_length    <= 16'd80;
      cfg_r.bit_gap_length  <= 16'd50;
      cfg_r.byte_gap_length <= 16'd67;
      cfg_r.zero_min        <= 16'd24;
      cfg_r.zero_max        <= 16'd30;
      cfg_r.one_length      <= 16'd70;
      cfg_r.tolerance       <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  etsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_data  (op_data)
  );

  etsfd_back #(
    .MAX_EDGES  (MAX_EDGES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op_data   (op_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/etsfd_checker.sv =====
// Port-level checks for the frame decoder and the bind that attaches them.
`default_nettype none

module etsfd_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire etsfd_pkg::out_item_t out_data
);
  import etsfd_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Words are reported only for frames that decoded fully.
  a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK && out_data.status != ST_CHECKSUM
    |-> out_data.humidity == 16'd0 && out_data.temperature == 16'd0)
    else $error("data words set on a failed frame");

  // Only defined status codes leave the block.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_OVERFLOW)
    else $error("undefined status code");

endmodule

bind edge_timing_sensor_frame_decoder_unit etsfd_checker u_etsfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_edge_timing_sensor_frame_decoder_unit.sv =====
// Self-checking testbench for the edge timing sensor frame decoder unit.
`timescale 1ns / 100ps

module tb_edge_timing_sensor_frame_decoder_unit;
  import etsfd_pkg::*;

  localparam int          MAX_EDGES      = 84;
  localparam int          TIME_WIDTH     = 16;
  localparam int unsigned IDLE_PERCENT   = 17;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RANDOM_BEATS   = 1800;
  localparam int unsigned PHASE_BEATS    = 250;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // Ways a generated frame departs from a clean sensor reply.
  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_TIMING,
    FAULT_POLARITY,
    FAULT_SHORT,
    FAULT_RISING_FIRST,
    FAULT_SURPLUS
  } frame_fault_t;

  // Tracks the decoder state beat by beat and holds the reports it should produce.
  class frame_scoreboard;
    cfg_regs_t   regs;
    logic [15:0] prev_time;
    logic [6:0]  edge_cnt;
    logic        last_pol;
    logic        first_falling;
    status_t     err;
    logic [39:0] frame;
    logic [5:0]  bits_rx;
    out_item_t   expected_reports[$];
    int unsigned mismatch_count;

    function new();
      regs.start_length    = 16'd80;
      regs.bit_gap_length  = 16'd50;
      regs.byte_gap_length = 16'd67;
      regs.zero_min        = 16'd24;
      regs.zero_max        = 16'd30;
      regs.one_length      = 16'd70;
      regs.tolerance       = 8'd5;
      mismatch_count       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      prev_time     = '0;
      edge_cnt      = '0;
      last_pol      = 1'b0;
      first_falling = 1'b0;
      err           = ST_OK;
      frame         = '0;
      bits_rx       = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_START_LENGTH:    regs.start_length    = val;
        CFG_BIT_GAP_LENGTH:  regs.bit_gap_length  = val;
        CFG_BYTE_GAP_LENGTH: regs.byte_gap_length = val;
        CFG_ZERO_MIN:        regs.zero_min        = val;
        CFG_ZERO_MAX:        regs.zero_max        = val;
        CFG_ONE_LENGTH:      regs.one_length      = val;
        CFG_TOLERANCE:       regs.tolerance       = val[7:0];
        default: ;
      endcase
    endfunction

    // The low end of a window saturates at zero; the high end may pass 16 bits.
    function bit in_window(logic [15:0] v, logic [15:0] nominal);
      int unsigned lo, hi;
      lo = (nominal > regs.tolerance) ? int'(nominal) - int'(regs.tolerance) : 0;
      hi = int'(nominal) + int'(regs.tolerance);
      return (v >= lo) && (v <= hi);
    endfunction

    function void note_beat(in_item_t beat);
      logic [15:0] dt;
      logic [15:0] nominal;
      int unsigned j;
      logic [7:0]  sum;
      out_item_t   rep;
      case (beat.command)
        CMD_START: clear_frame();
        CMD_EDGE: begin
          // The first error latches; later edges are ignored until a start.
          if (err == ST_OK) begin
            if (edge_cnt >= MAX_EDGES) begin
              err = ST_OVERFLOW;
            end else if (edge_cnt != 0 && beat.edge_rising == last_pol) begin
              err = ST_POLARITY;
            end else begin
              if (edge_cnt == 0) begin
                first_falling = !beat.edge_rising;
                if (beat.edge_rising) err = ST_START;
              end else begin
                dt = beat.capture_time - prev_time;
                if (edge_cnt <= 2) begin
                  if (!in_window(dt, regs.start_length)) err = ST_START;
                end else if (edge_cnt == 3) begin
                  if (!in_window(dt, regs.bit_gap_length)) err = ST_TIMING;
                end else if (edge_cnt <= LAST_CHECKED_EDGE) begin
                  j = edge_cnt - 4;
                  if (j % 2 == 0) begin
                    // High pulse: the zero window is tried before the one window.
                    if (dt >= regs.zero_min && dt <= regs.zero_max) begin
                      frame = {frame[38:0], 1'b0};
                      bits_rx++;
                    end else if (in_window(dt, regs.one_length)) begin
                      frame = {frame[38:0], 1'b1};
                      bits_rx++;
                    end else begin
                      err = ST_TIMING;
                    end
                  end else begin
                    nominal = ((j / 2) % 8 == 7) ? regs.byte_gap_length : regs.bit_gap_length;
                    if (!in_window(dt, nominal)) err = ST_TIMING;
                  end
                end
              end
              last_pol  = beat.edge_rising;
              prev_time = beat.capture_time;
              edge_cnt++;
            end
          end
        end
        CMD_END: begin
          rep.humidity    = '0;
          rep.temperature = '0;
          if (err != ST_OK) begin
            rep.status = err;
          end else if (edge_cnt == 0 || !first_falling) begin
            rep.status = ST_START;
          end else if (bits_rx < FRAME_BITS) begin
            rep.status = ST_TIMING;
          end else begin
            sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
            rep.humidity    = frame[39:24];
            rep.temperature = frame[23:8];
            rep.status      = (sum == frame[7:0]) ? ST_OK : ST_CHECKSUM;
          end
          expected_reports.push_back(rep);
        end
        default: ;
      endcase
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result beat with none expected: status %0d humidity %h temperature %h",
                 $time, got.status, got.humidity, got.temperature);
        mismatch_count++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
        mismatch_count++;
      end
      if (got.humidity !== want.humidity) begin
        $display("%0t: humidity expected %h, actual %h", $time, want.humidity, got.humidity);
        mismatch_count++;
      end
      if (got.temperature !== want.temperature) begin
        $display("%0t: temperature expected %h, actual %h", $time, want.temperature,
                 got.temperature);
        mismatch_count++;
      end
    endfunction

    function int unsigned reports_waiting();
      return expected_reports.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_data;

  frame_scoreboard sb;
  logic [15:0]     cur_time;
  int unsigned     beats_sent;
  int unsigned     stall_cycles;
  bit              hold_req;
  bit              calm;

  edge_timing_sensor_frame_decoder_unit #(
    .MAX_EDGES  (MAX_EDGES),
    .TIME_WIDTH (TIME_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every accepted beat on any channel is handed to the scoreboard at the edge it moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_beat(in_data);
      if (out_valid && out_ready) sb.check_report(out_data);
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk);
      end
    end
  end

  // End the run if no beat moves on any channel for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_item_t make_beat(input logic [1:0] command, input logic rising,
                                         input logic [15:0] stamp);
    in_item_t beat;
    beat.command      = command;
    beat.edge_rising  = rising;
    beat.capture_time = stamp;
    return beat;
  endfunction

  // Random interval inside the current window around a nominal length.
  function automatic logic [15:0] pick_near(input logic [15:0] nominal);
    int unsigned lo, hi;
    lo = (nominal > sb.regs.tolerance) ? int'(nominal) - int'(sb.regs.tolerance) : 0;
    hi = int'(nominal) + int'(sb.regs.tolerance);
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic send_item(input in_item_t beat);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (beat.command != CMD_UNUSED) beats_sent++;
  endtask

  // Stop sending, wait for every report, then let queued edges drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.reports_waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register, tolerance with junk in its upper byte, and the unused index.
  task automatic apply_settings(input cfg_regs_t plan);
    cfg_beat(CFG_START_LENGTH, plan.start_length);
    cfg_beat(CFG_BIT_GAP_LENGTH, plan.bit_gap_length);
    cfg_beat(CFG_BYTE_GAP_LENGTH, plan.byte_gap_length);
    cfg_beat(CFG_ZERO_MIN, plan.zero_min);
    cfg_beat(CFG_ZERO_MAX, plan.zero_max);
    cfg_beat(CFG_ONE_LENGTH, plan.one_length);
    cfg_beat(CFG_TOLERANCE, {8'($urandom()), plan.tolerance});
    cfg_beat(CFG_UNUSED_IDX, 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // One start beat and a frame of edges timed for the current windows, with an optional fault.
  task automatic send_frame(input frame_fault_t fault);
    logic [31:0] data;
    logic [7:0]  sum;
    logic [39:0] payload;
    int unsigned last_k, bad_k;
    logic        rising;
    logic [15:0] dt;
    data = $urandom();
    sum  = data[31:24] + data[23:16] + data[15:8] + data[7:0];
    if ($urandom_range(99) < 80) payload = {data, sum};
    else payload = {data, 8'($urandom())};
    last_k = LAST_CHECKED_EDGE;
    if (fault == FAULT_SHORT) last_k = $urandom_range(LAST_CHECKED_EDGE - 1, 0);
    else if (fault == FAULT_SURPLUS) last_k = LAST_CHECKED_EDGE + $urandom_range(3, 1);
    bad_k = $urandom_range(LAST_CHECKED_EDGE, 1);
    send_item(make_beat(CMD_START, 1'($urandom_range(1)), 16'($urandom())));
    for (int k = 0; k <= int'(last_k); k++) begin
      if (k == 0 || k > int'(LAST_CHECKED_EDGE)) begin
        dt = 16'($urandom());
      end else if (k <= 2) begin
        dt = pick_near(sb.regs.start_length);
      end else if (k == 3) begin
        dt = pick_near(sb.regs.bit_gap_length);
      end else if (k % 2 == 0) begin
        // Data bits go out most significant first.
        if (payload[39 - (k - 4) / 2])
          dt = pick_near(sb.regs.one_length);
        else
          dt = 16'($urandom_range(sb.regs.zero_max, sb.regs.zero_min));
      end else if (((k - 5) / 2) % 8 == 7) begin
        dt = pick_near(sb.regs.byte_gap_length);
      end else begin
        dt = pick_near(sb.regs.bit_gap_length);
      end
      if (fault == FAULT_TIMING && k == int'(bad_k)) dt = 16'($urandom());
      rising = (k % 2 == 1);
      if ((fault == FAULT_POLARITY && k == int'(bad_k)) || (fault == FAULT_RISING_FIRST && k == 0))
        rising = !rising;
      cur_time = cur_time + dt;
      send_item(make_beat(CMD_EDGE, rising, cur_time));
    end
  endtask

  initial begin : stimulus
    cfg_regs_t    plan;
    frame_fault_t fault;
    int unsigned  r, phase, next_mark, n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_START_LENGTH;
    cfg_data   = '0;
    cur_time   = '0;
    beats_sent = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: end with no edges, the unused command, first edge rising, polarity repeat,
    // a timer wrap with too few bits and a repeated end, and a start window miss.
    send_item(make_beat(CMD_END, 1'b0, 16'h0000));
    send_item(make_beat(CMD_UNUSED, 1'b1, 16'hFFFF));
    send_item(make_beat(CMD_START, 1'b1, 16'hFFFF));
    send_item(make_beat(CMD_EDGE, 1'b1, 16'h0000));
    send_item(make_beat(CMD_END, 1'b1, 16'hFFFF));
    send_item(make_beat(CMD_START, 1'b0, 16'h0000));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'h1000));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'h1050));
    send_item(make_beat(CMD_END, 1'b0, 16'h0000));
    send_item(make_beat(CMD_START, 1'b0, 16'h0000));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'hFFF0));
    send_item(make_beat(CMD_EDGE, 1'b1, 16'h0040));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'h0090));
    send_item(make_beat(CMD_EDGE, 1'b1, 16'h00C2));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'h00DA));
    send_item(make_beat(CMD_END, 1'b0, 16'h0000));
    send_item(make_beat(CMD_END, 1'b1, 16'hFFFF));
    send_item(make_beat(CMD_START, 1'b0, 16'h0000));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'h0000));
    send_item(make_beat(CMD_EDGE, 1'b1, 16'd75));
    send_item(make_beat(CMD_EDGE, 1'b0, 16'd161));
    send_item(make_beat(CMD_END, 1'b0, 16'h0000));

    // Random part in phases, each under its own register settings.
    beats_sent = 0;
    phase      = 0;
    next_mark  = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= next_mark) begin
        wait_drained();
        case (phase)
          0: plan = {16'd80, 16'd50, 16'd67, 16'd24, 16'd30, 16'd70, 8'd5};
          1: plan = '0;
          2: plan = '1;
          3: plan = {16'd1000, 16'd400, 16'd700, 16'd100, 16'd200, 16'd600, 8'd20};
          4: plan = {16'd3, 16'd9, 16'd250, 16'd10, 16'd20, 16'd40, 8'd255};
          default: begin
            plan.tolerance       = 8'($urandom_range(60));
            plan.start_length    = 16'($urandom_range(3000, 1));
            plan.bit_gap_length  = 16'($urandom_range(1500));
            plan.byte_gap_length = 16'($urandom_range(1500));
            plan.zero_min        = 16'($urandom_range(400));
            plan.zero_max        = plan.zero_min + 16'($urandom_range(200));
            plan.one_length      = plan.zero_max + 16'($urandom_range(600, 1));
          end
        endcase
        apply_settings(plan);
        calm <= (phase == 4);
        // Hold off the result side while end beats keep coming, so the input backs up.
        if (phase == 1) begin
          hold_req <= 1'b1;
          repeat (16) send_item(make_beat(CMD_END, 1'($urandom_range(1)), 16'($urandom())));
        end
        phase++;
        next_mark += PHASE_BEATS;
      end

      r = $urandom_range(99);
      if (r < 84) begin
        if (r < 45) fault = FAULT_NONE;
        else if (r < 55) fault = FAULT_TIMING;
        else if (r < 62) fault = FAULT_POLARITY;
        else if (r < 72) fault = FAULT_SHORT;
        else if (r < 76) fault = FAULT_RISING_FIRST;
        else fault = FAULT_SURPLUS;
        send_frame(fault);
        if ($urandom_range(99) < 90)
          send_item(make_beat(CMD_END, 1'($urandom_range(1)), 16'($urandom())));
        if ($urandom_range(99) < 20)
          send_item(make_beat(CMD_END, 1'($urandom_range(1)), 16'($urandom())));
      end else begin
        // Noise: any command, any polarity, any time stamp.
        n = $urandom_range(8, 1);
        repeat (n) send_item(make_beat(2'($urandom_range(3)), 1'($urandom_range(1)),
                                       16'($urandom())));
      end
    end

    wait_drained();
    if (sb.mismatch_count == 0 && sb.reports_waiting() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
